@@ src/frt_pkg.sv @@
// package for the fragment reassembly tracker: types, codes, defaults
package frt_pkg;

	localparam int FLOWS_DEF = 4;
	localparam int SLOTS_DEF = 8;
	localparam int MAXFRAG_DEF = 256;
	localparam logic [31:0] EXPIRY_RESET = 32'd8;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_COMPLETED = 3'd1,
		ST_ZERO      = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_BAD_INDEX = 3'd4,
		ST_DUPLICATE = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0]  flow_number;
		logic [31:0] frame_number;
		logic [15:0] fragment_index;
		logic [15:0] fragment_total;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  pixel_encoding;
		logic [31:0] byte_offset;
		logic [15:0] payload_length;
		logic [31:0] arrival_time;
	} frag_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_flow;
		logic [31:0] out_frame;
		logic [31:0] write_offset;
		logic [15:0] write_length;
		logic [31:0] total_size;
		logic [31:0] first_time;
		logic [31:0] dropped_count;
		logic [15:0] done_width;
		logic [15:0] done_height;
		logic [7:0]  done_encoding;
	} frag_out_t;

endpackage

@@ src/fragment_reassembly_tracker.sv @@
// fragment reassembly tracker: per-flow slot table with a shared scan compare
//
//  channel   signals                     handshake
//  header    start, busy, hdr            taken when start && !busy
//  result    res_valid, res              one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data            written when cfg_we is high
//
// a header that reaches the bitmap keeps busy high through an oldest-frame scan and drop
//   decision for each expired frame it drops and one more, then the frame and free-slot scan,
//   then read, metadata, bitmap read, bitmap check and result
// a flow out of range goes straight to the result; zero size or a full table end after the
//   read, a mismatch or bad index after the bitmap read
// reset clears slot valid bits and the drop counter; a bitmap word is cleared on allocation
// the result strobe cannot be stalled; busy stays high through the result cycle
module fragment_reassembly_tracker import frt_pkg::*; #(
	parameter int FLOWS = FLOWS_DEF,
	parameter int SLOTS_PER_FLOW = SLOTS_DEF,
	parameter int MAX_FRAGMENTS = MAXFRAG_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  frag_in_t    hdr,
	output logic        res_valid,
	output frag_out_t   res,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data
);
	localparam int SW = (SLOTS_PER_FLOW > 1) ? $clog2(SLOTS_PER_FLOW) : 1;
	localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int NS = FLOWS * SLOTS_PER_FLOW;
	localparam int AW = (NS > 1) ? $clog2(NS) : 1;
	localparam int BW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CW = $clog2(SLOTS_PER_FLOW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MIN, S_DROP, S_FIND, S_READ, S_META, S_BMRD, S_BMCHK, S_DONE
	} state_t;

	// slot storage; valid bits are flip-flops, the rest undefined until written
	logic [NS-1:0]   valid_q;
	logic [31:0]     frame_mem [NS];
	logic [55:0]     meta_mem  [NS];
	logic [31:0]     size_mem  [NS];
	logic [31:0]     time_mem  [NS];
	logic [15:0]     recv_mem  [NS];
	logic [MAX_FRAGMENTS-1:0] bm_mem [NS];

	state_t      state_q;
	frag_in_t    h_q;
	logic [31:0] expiry_q, drops_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] best_q, hit_q, free_q;
	logic        best_ok_q, hit_ok_q, free_ok_q;
	logic [31:0] best_frame_q;
	logic [31:0] rd_size_q, rd_time_q;
	logic [55:0] rd_meta_q;
	logic [15:0] rd_recv_q;
	logic [MAX_FRAGMENTS-1:0] rd_bm_q;
	logic        new_q;
	frag_out_t   res_q;

	logic [FW-1:0] flow_idx;
	logic [SW-1:0] scan_slot;
	logic [AW-1:0] scan_addr, hit_addr;
	logic [55:0]   meta_in;
	logic [32:0]   end_sum;
	logic [31:0]   end_sat;
	logic [BW-1:0] bit_idx;
	logic          scan_v;
	logic          dup_bit;
	logic [MAX_FRAGMENTS-1:0] bm_next;
	frag_out_t     res_init;

	assign flow_idx  = FW'(h_q.flow_number);
	assign scan_slot = cnt_q[SW-1:0];
	assign scan_addr = AW'(flow_idx * SLOTS_PER_FLOW + scan_slot);
	assign hit_addr  = AW'(flow_idx * SLOTS_PER_FLOW + hit_q);
	assign scan_v    = valid_q[scan_addr];
	assign meta_in   = {h_q.image_width, h_q.image_height, h_q.pixel_encoding,
		h_q.fragment_total};
	assign end_sum   = {1'b0, h_q.byte_offset} + {17'd0, h_q.payload_length};
	assign end_sat   = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
	assign bit_idx   = BW'(h_q.fragment_index);
	assign dup_bit   = rd_bm_q[bit_idx];

	// bitmap word with this fragment's bit set
	always_comb begin
		bm_next = rd_bm_q;
		bm_next[bit_idx] = 1'b1;
	end

	// result word as first loaded when a header is taken
	always_comb begin
		res_init = '0;
		res_init.out_flow  = hdr.flow_number;
		res_init.out_frame = hdr.frame_number;
		if (32'(hdr.flow_number) >= FLOWS) begin
			res_init.status        = ST_FULL;
			res_init.dropped_count = drops_q;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			drops_q   <= '0;
			expiry_q  <= EXPIRY_RESET;
			cnt_q     <= '0;
			best_ok_q <= 1'b0;
			hit_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
			new_q     <= 1'b0;
		end else begin
			if (cfg_we) expiry_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						h_q       <= hdr;
						cnt_q     <= '0;
						best_ok_q <= 1'b0;
						res_q     <= res_init;
						if (32'(hdr.flow_number) >= FLOWS) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MIN;
						end
					end
				end
				// find the oldest valid frame, one slot a cycle
				S_MIN: begin
					if (scan_v && (!best_ok_q || frame_mem[scan_addr] < best_frame_q)) begin
						best_ok_q    <= 1'b1;
						best_q       <= scan_slot;
						best_frame_q <= frame_mem[scan_addr];
					end
					if (cnt_q == CW'(SLOTS_PER_FLOW - 1)) state_q <= S_DROP;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DROP: begin
					cnt_q <= '0;
					if (best_ok_q && h_q.frame_number >= best_frame_q + expiry_q) begin
						valid_q[AW'(flow_idx * SLOTS_PER_FLOW + best_q)] <= 1'b0;
						drops_q   <= drops_q + 1'b1;
						best_ok_q <= 1'b0;
						state_q   <= S_MIN;
					end else begin
						hit_ok_q  <= 1'b0;
						free_ok_q <= 1'b0;
						state_q   <= S_FIND;
					end
				end
				// look for the frame and the lowest free slot
				S_FIND: begin
					if (scan_v && frame_mem[scan_addr] == h_q.frame_number && !hit_ok_q) begin
						hit_ok_q <= 1'b1;
						hit_q    <= scan_slot;
					end
					if (!scan_v && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= scan_slot;
					end
					if (cnt_q == CW'(SLOTS_PER_FLOW - 1)) state_q <= S_READ;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_READ: begin
					res_q.dropped_count <= drops_q;
					if (hit_ok_q) begin
						new_q   <= 1'b0;
						state_q <= S_META;
					end else if (end_sum == '0) begin
						res_q.status <= ST_ZERO;
						state_q      <= S_DONE;
					end else if (!free_ok_q) begin
						res_q.status <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						hit_q   <= free_q;
						new_q   <= 1'b1;
						valid_q[AW'(flow_idx * SLOTS_PER_FLOW + free_q)] <= 1'b1;
						state_q <= S_META;
					end
				end
				S_META: begin
					rd_meta_q  <= new_q ? meta_in : meta_mem[hit_addr];
					rd_size_q  <= new_q ? end_sat : size_mem[hit_addr];
					rd_time_q  <= new_q ? h_q.arrival_time : time_mem[hit_addr];
					rd_recv_q  <= new_q ? 16'd0 : recv_mem[hit_addr];
					state_q    <= S_BMRD;
				end
				S_BMRD: begin
					res_q.total_size <= rd_size_q;
					if (rd_meta_q != meta_in) begin
						res_q.status <= ST_MISMATCH;
						state_q      <= S_DONE;
					end else if (h_q.fragment_index >= h_q.fragment_total ||
							32'(h_q.fragment_index) >= MAX_FRAGMENTS) begin
						res_q.status <= ST_BAD_INDEX;
						state_q      <= S_DONE;
					end else begin
						rd_bm_q <= bm_mem[hit_addr];
						state_q <= S_BMCHK;
					end
				end
				S_BMCHK: begin
					state_q <= S_DONE;
					if (dup_bit) begin
						res_q.status <= ST_DUPLICATE;
					end else begin
						res_q.write_offset <= h_q.byte_offset;
						res_q.write_length <= h_q.payload_length;
						if ({1'b0, rd_size_q} < end_sum) res_q.total_size <= end_sat;
						if (rd_recv_q + 16'd1 == h_q.fragment_total) begin
							res_q.status        <= ST_COMPLETED;
							res_q.first_time    <= rd_time_q;
							res_q.done_width    <= rd_meta_q[55:40];
							res_q.done_height   <= rd_meta_q[39:24];
							res_q.done_encoding <= rd_meta_q[23:16];
							valid_q[hit_addr]   <= 1'b0;
						end else begin
							res_q.status <= ST_STORED;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// slot memory writes, one address per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_META && new_q) begin
			frame_mem[hit_addr] <= h_q.frame_number;
			meta_mem[hit_addr]  <= meta_in;
			size_mem[hit_addr]  <= end_sat;
			time_mem[hit_addr]  <= h_q.arrival_time;
		end
		if (state_q == S_BMCHK && !dup_bit) begin
			recv_mem[hit_addr] <= rd_recv_q + 16'd1;
			if ({1'b0, rd_size_q} < end_sum) size_mem[hit_addr] <= end_sat;
		end else if (state_q == S_META && new_q) begin
			recv_mem[hit_addr] <= 16'd0;
		end
	end

	// bitmap: one word per slot, cleared on allocation, read-modify-write per fragment
	always_ff @(posedge clk) begin
		if (state_q == S_META && new_q)
			bm_mem[hit_addr] <= '0;
		else if (state_q == S_BMCHK && !dup_bit)
			bm_mem[hit_addr] <= bm_next;
	end
endmodule

@@ src/frt_checker.sv @@
// port-level checker for the fragment reassembly tracker, bound to the top
module frt_checker import frt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      res_valid,
	input frag_out_t res
);
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid) else $error("result strobe longer than one cycle");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy) else $error("result outside busy");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status != 3'd7) else $error("bad status code");
	a_write_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_STORED && res.status != ST_COMPLETED
		|-> res.write_length == 16'd0) else $error("write length on failed word");
endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.res_valid(res_valid), .res(res)
);
